### design/lcdw_pkg.sv
// Shared types, constants and the digit pattern table for the LCD digit writer.
// No dependencies.
package lcdw_pkg;

    localparam int unsigned SEG_ROWS = 4;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Row 0 keeps these bits of the written nibble
    localparam logic [3:0] ROW0_KEEP = 4'h6;

    typedef logic [3:0] nibble_t;
    typedef logic [7:0] seg_byte_t;
    typedef nibble_t  [SEG_ROWS-1:0] row_nibbles_t;
    typedef seg_byte_t [SEG_ROWS-1:0] row_bytes_t;

    // Nibble pattern for rows 0..3 of a decimal digit
    function automatic row_nibbles_t digit_pattern(input logic [3:0] digit);
        row_nibbles_t pat;
        begin
            case (digit)
                4'd0:    pat = {4'h1, 4'h5, 4'h5, 4'h1};
                4'd1:    pat = {4'h0, 4'h1, 4'h1, 4'h0};
                4'd2:    pat = {4'h1, 4'he, 4'h1, 4'h1};
                4'd3:    pat = {4'h1, 4'hb, 4'h1, 4'h1};
                4'd4:    pat = {4'h0, 4'hb, 4'h5, 4'h0};
                4'd5:    pat = {4'h1, 4'hb, 4'h4, 4'h1};
                4'd6:    pat = {4'h1, 4'hf, 4'h4, 4'h1};
                4'd7:    pat = {4'h0, 4'h1, 4'h1, 4'h1};
                4'd8:    pat = {4'h1, 4'hf, 4'h5, 4'h1};
                4'd9:    pat = {4'h1, 4'hb, 4'h5, 4'h1};
                default: pat = '0;
            endcase
            return pat;
        end
    endfunction

endpackage

### design/lcdw_nibble_merge.sv
// Merges a character's segment pattern into one nibble of a four-row byte column.
// Depends on lcdw_pkg.
module lcdw_nibble_merge (
    input  lcdw_pkg::row_bytes_t old_bytes,
    input  logic [7:0]           digit_char,
    input  logic                 odd_nibble,
    output lcdw_pkg::row_bytes_t new_bytes
);
    import lcdw_pkg::*;

    logic         is_digit;
    logic [7:0]   digit_ofs;
    row_nibbles_t pattern;
    nibble_t      old_nib [SEG_ROWS];
    nibble_t      new_nib [SEG_ROWS];

    assign is_digit  = (digit_char >= CHAR_ZERO) && (digit_char <= CHAR_NINE);
    assign digit_ofs = digit_char - CHAR_ZERO;
    assign pattern   = is_digit ? digit_pattern(digit_ofs[3:0]) : '0;

    always_comb begin
        for (int r = 0; r < SEG_ROWS; r++) begin
            old_nib[r] = odd_nibble ? old_bytes[r][7:4] : old_bytes[r][3:0];
            // row 0 holds two annunciator bits inside the digit nibble
            new_nib[r] = ((r == 0) ? (old_nib[r] & ROW0_KEEP) : 4'h0) | pattern[r];
            new_bytes[r] = odd_nibble ? {new_nib[r], old_bytes[r][3:0]}
                                      : {old_bytes[r][7:4], new_nib[r]};
        end
    end

endmodule

### design/lcd_digit_segment_writer_core.sv
// Top level of the LCD digit writer: input register, segment store, result register.
// Depends on lcdw_pkg and lcdw_nibble_merge.
//
//   channel | ports                                  | direction
//   s_      | s_valid s_ready s_digit_char s_digit_position | word in
//   m_      | m_valid m_ready m_column_index m_row0..3_byte | word out
//
// One word per cycle sustained while the m_ side accepts; a taken word passes through
// the input register, then the result register. The store update and result load
// share one edge, so a following word sees the new bytes. Words with a position at
// or above DIGIT_COUNT are dropped without a result. Reset clears the store and all
// valid flags. A stalled m_ side holds the result and backs up into s_ready.
module lcd_digit_segment_writer_core #(
    parameter int DIGIT_COUNT = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_digit_char,
    input  logic [3:0] s_digit_position,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_column_index,
    output logic [7:0] m_row0_byte,
    output logic [7:0] m_row1_byte,
    output logic [7:0] m_row2_byte,
    output logic [7:0] m_row3_byte
);
    import lcdw_pkg::*;

    localparam int         COLS      = (DIGIT_COUNT + 1) / 2;
    localparam int         COL_W     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam logic [3:0] POS_LIMIT = 4'(DIGIT_COUNT);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic [3:0] in_pos_reg;

    logic       out_valid_reg;
    logic [1:0] column_reg;
    row_bytes_t rows_reg;

    logic [7:0] store_reg [SEG_ROWS][COLS];

    logic             in_hit;
    logic             out_free;
    logic             stage_move;
    logic             wr_en;
    logic [2:0]       col_full;
    logic [COL_W-1:0] col_idx;
    row_bytes_t       old_bytes;
    row_bytes_t       new_bytes;

    assign in_hit     = in_pos_reg < POS_LIMIT;
    assign out_free   = !out_valid_reg || m_ready;
    assign stage_move = in_valid_reg && (!in_hit || out_free);
    assign wr_en      = in_valid_reg && in_hit && out_free;
    assign s_ready    = !in_valid_reg || stage_move;

    assign col_full = in_pos_reg[3:1];
    assign col_idx  = col_full[COL_W-1:0];

    always_comb begin
        for (int r = 0; r < SEG_ROWS; r++) begin
            old_bytes[r] = store_reg[r][col_idx];
        end
    end

    lcdw_nibble_merge u_merge (
        .old_bytes  (old_bytes),
        .digit_char (in_char_reg),
        .odd_nibble (in_pos_reg[0]),
        .new_bytes  (new_bytes)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_digit_char;
            in_pos_reg  <= s_digit_position;
        end
    end

    // segment store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < SEG_ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    store_reg[r][c] <= '0;
                end
            end
        end else if (wr_en) begin
            for (int r = 0; r < SEG_ROWS; r++) begin
                store_reg[r][col_idx] <= new_bytes[r];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (wr_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            column_reg <= col_full[1:0];
            rows_reg   <= new_bytes;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_column_index = column_reg;
    assign m_row0_byte    = rows_reg[0];
    assign m_row1_byte    = rows_reg[1];
    assign m_row2_byte    = rows_reg[2];
    assign m_row3_byte    = rows_reg[3];

endmodule
